/* rtl/ccs_pkg.sv */
// Shared types and codes for the Chaikin curve subdivider.
// Used by ccs_cut_unit and chaikin_curve_subdivider; depends on nothing.
package ccs_pkg;

    typedef enum logic [1:0] {
        OP_ADD     = 2'd0,
        OP_CLEAR   = 2'd1,
        OP_ITERATE = 2'd2,
        OP_UNUSED  = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        STAT_ADDED   = 3'd0,
        STAT_CLEARED = 3'd1,
        STAT_POINT   = 3'd2,
        STAT_REFUSED = 3'd3,
        STAT_EMPTIED = 3'd4
    } status_t;

    typedef enum logic {
        STEP_QUARTER       = 1'b0,
        STEP_THREE_QUARTER = 1'b1
    } step_t;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_PRIME = 4'b0010,
        ST_CUT_A = 4'b0100,
        ST_CUT_B = 4'b1000
    } state_t;

endpackage

/* rtl/ccs_point_mem.sv */
// Point store: one write port and one registered read port.
// Holds both banks of packed {y, x} points; no dependencies.
module ccs_point_mem #(
    parameter int ADDR_W = 6,
    parameter int DATA_W = 32
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [0:(1 << ADDR_W)-1];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/ccs_cut_unit.sv */
// Corner-cut arithmetic: p0 + floor(d/4) or p0 + floor(3d/4) on both axes.
// Depends on ccs_pkg for the step select.
module ccs_cut_unit
    import ccs_pkg::*;
#(
    parameter int COORD_BITS = 16
) (
    input  step_t                  step,
    input  logic [COORD_BITS-1:0]  p0_x,
    input  logic [COORD_BITS-1:0]  p0_y,
    input  logic [COORD_BITS-1:0]  p1_x,
    input  logic [COORD_BITS-1:0]  p1_y,
    output logic [COORD_BITS-1:0]  q_x,
    output logic [COORD_BITS-1:0]  q_y
);

    localparam int EXT_W = COORD_BITS + 3;

    function automatic logic [COORD_BITS-1:0] cut(input logic [COORD_BITS-1:0] a,
                                                 input logic [COORD_BITS-1:0] b,
                                                 input step_t s);
        logic signed [EXT_W-1:0] ea;
        logic signed [EXT_W-1:0] d;
        logic signed [EXT_W-1:0] t;
        logic signed [EXT_W-1:0] r;
        ea = EXT_W'(signed'(a));
        d  = EXT_W'(signed'(b)) - ea;
        t  = (s == STEP_THREE_QUARTER) ? (d + (d <<< 1)) : d;
        r  = ea + (t >>> 2);
        return r[COORD_BITS-1:0];
    endfunction

    assign q_x = cut(p0_x, p1_x, step);
    assign q_y = cut(p0_y, p1_y, step);

endmodule

/* rtl/chaikin_curve_subdivider.sv */
// Top level of the Chaikin curve subdivider: sequencer, bank control and output register.
// Depends on ccs_pkg, ccs_point_mem and ccs_cut_unit.
//
//   Port group   Dir  tdata (low bit up)              tuser    tlast
//   s_*          in   x_coord, y_coord                opcode   -
//   m_*          out  out_x, out_y, point_count       status   last
//
// Add, clear, refused commands and emptying iterates give one beat. A successful iterate
// loads the first point in ST_PRIME, then gives a quarter cut in ST_CUT_A and a
// three-quarter cut in ST_CUT_B per segment, set by the single read port of the point
// store and the shared cut unit. New points go to the other bank, which becomes current
// at the end. Reset is synchronous and clears control state only. A stalled output
// holds the sequencer; no input is taken while a beat is pending.
module chaikin_curve_subdivider
    import ccs_pkg::*;
#(
    parameter int MAX_POINTS = 32,
    parameter int COORD_BITS = 16
) (
    input  logic                                                 aclk,
    input  logic                                                 aresetn,
    input  logic                                                 s_tvalid,
    output logic                                                 s_tready,
    // x_coord, y_coord
    input  logic [((2*COORD_BITS+7)/8)*8-1:0]                    s_tdata,
    // opcode
    input  logic [1:0]                                           s_tuser,
    output logic                                                 m_tvalid,
    input  logic                                                 m_tready,
    // out_x, out_y, point_count
    output logic [((2*COORD_BITS+$clog2(MAX_POINTS+1)+7)/8)*8-1:0] m_tdata,
    // status
    output logic [2:0]                                           m_tuser,
    output logic                                                 m_tlast
);

    localparam int IDX_W  = $clog2(MAX_POINTS);
    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int ADDR_W = IDX_W + 1;
    localparam int OUT_DW = ((2*COORD_BITS + CNT_W + 7) / 8) * 8;
    localparam int PT_W   = 2 * COORD_BITS;

    state_t            state_reg, state_next;
    logic              bank_reg, bank_next;
    logic [IDX_W-1:0]  wp_reg, wp_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  total_reg, total_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [IDX_W-1:0]  widx_reg, widx_next;
    logic [PT_W-1:0]   prev_reg, prev_next;

    logic                  m_valid_reg, m_valid_next;
    status_t               m_status_reg, m_status_next;
    logic [COORD_BITS-1:0] m_x_reg, m_x_next;
    logic [COORD_BITS-1:0] m_y_reg, m_y_next;
    logic [CNT_W-1:0]      m_count_reg, m_count_next;
    logic                  m_last_reg, m_last_next;

    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [PT_W-1:0]   wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [PT_W-1:0]   rd_data;

    step_t                 step;
    logic [COORD_BITS-1:0] cut_x, cut_y;

    logic                  in_fire;
    logic                  out_free;
    opcode_t               op;
    logic [COORD_BITS-1:0] in_x, in_y;
    logic [CNT_W:0]        dbl_count;
    logic                  is_last_new;
    logic                  more_segments;

    ccs_point_mem #(
        .ADDR_W (ADDR_W),
        .DATA_W (PT_W)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    ccs_cut_unit #(
        .COORD_BITS (COORD_BITS)
    ) u_cut (
        .step (step),
        .p0_x (prev_reg[COORD_BITS-1:0]),
        .p0_y (prev_reg[PT_W-1:COORD_BITS]),
        .p1_x (rd_data[COORD_BITS-1:0]),
        .p1_y (rd_data[PT_W-1:COORD_BITS]),
        .q_x  (cut_x),
        .q_y  (cut_y)
    );

    assign s_tready  = (state_reg == ST_IDLE) && !m_valid_reg;
    assign in_fire   = s_tvalid && s_tready;
    assign out_free  = !m_valid_reg || m_tready;
    assign op        = opcode_t'(s_tuser);
    assign in_x      = s_tdata[COORD_BITS-1:0];
    assign in_y      = s_tdata[PT_W-1:COORD_BITS];
    assign dbl_count = {count_reg, 1'b0} - (CNT_W+1)'(2);
    assign step      = (state_reg == ST_CUT_B) ? STEP_THREE_QUARTER : STEP_QUARTER;
    assign is_last_new   = (CNT_W'(widx_reg) + CNT_W'(1)) == total_reg;
    assign more_segments = (CNT_W'(idx_reg) + CNT_W'(1)) < count_reg;

    always_comb begin
        state_next    = state_reg;
        bank_next     = bank_reg;
        wp_next       = wp_reg;
        count_next    = count_reg;
        total_next    = total_reg;
        idx_next      = idx_reg;
        widx_next     = widx_reg;
        prev_next     = prev_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_status_next = m_status_reg;
        m_x_next      = m_x_reg;
        m_y_next      = m_y_reg;
        m_count_next  = m_count_reg;
        m_last_next   = m_last_reg;
        wr_en         = 1'b0;
        wr_addr       = {bank_reg, wp_reg};
        wr_data       = {in_y, in_x};
        rd_en         = 1'b0;
        rd_addr       = {bank_reg, IDX_W'(0)};

        unique case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    m_valid_next = 1'b1;
                    m_x_next     = '0;
                    m_y_next     = '0;
                    m_last_next  = 1'b1;
                    unique case (op)
                        OP_ADD: begin
                            wr_en   = 1'b1;
                            wp_next = (wp_reg == IDX_W'(MAX_POINTS - 1)) ?
                                      '0 : wp_reg + IDX_W'(1);
                            if (count_reg != CNT_W'(MAX_POINTS)) begin
                                count_next = count_reg + CNT_W'(1);
                            end
                            m_status_next = STAT_ADDED;
                            m_count_next  = count_next;
                        end
                        OP_CLEAR: begin
                            wp_next       = '0;
                            count_next    = '0;
                            m_status_next = STAT_CLEARED;
                            m_count_next  = '0;
                        end
                        OP_ITERATE: begin
                            if (count_reg == '0 ||
                                dbl_count >= (CNT_W+1)'(MAX_POINTS)) begin
                                m_status_next = STAT_REFUSED;
                                m_count_next  = count_reg;
                            end else if (count_reg == CNT_W'(1)) begin
                                wp_next       = '0;
                                count_next    = '0;
                                m_status_next = STAT_EMPTIED;
                                m_count_next  = '0;
                            end else begin
                                m_valid_next = 1'b0;
                                rd_en        = 1'b1;
                                total_next   = dbl_count[CNT_W-1:0];
                                idx_next     = IDX_W'(1);
                                widx_next    = '0;
                                state_next   = ST_PRIME;
                            end
                        end
                        OP_UNUSED: begin
                            m_status_next = STAT_REFUSED;
                            m_count_next  = count_reg;
                        end
                        default: begin
                            m_status_next = STAT_REFUSED;
                            m_count_next  = count_reg;
                        end
                    endcase
                end
            end
            ST_PRIME: begin
                prev_next  = rd_data;
                rd_en      = 1'b1;
                rd_addr    = {bank_reg, idx_reg};
                state_next = ST_CUT_A;
            end
            ST_CUT_A: begin
                if (out_free) begin
                    wr_en         = 1'b1;
                    wr_addr       = {!bank_reg, widx_reg};
                    wr_data       = {cut_y, cut_x};
                    m_valid_next  = 1'b1;
                    m_status_next = STAT_POINT;
                    m_x_next      = cut_x;
                    m_y_next      = cut_y;
                    m_count_next  = total_reg;
                    m_last_next   = is_last_new;
                    widx_next     = widx_reg + IDX_W'(1);
                    state_next    = ST_CUT_B;
                end
            end
            ST_CUT_B: begin
                if (out_free) begin
                    wr_en         = 1'b1;
                    wr_addr       = {!bank_reg, widx_reg};
                    wr_data       = {cut_y, cut_x};
                    m_valid_next  = 1'b1;
                    m_status_next = STAT_POINT;
                    m_x_next      = cut_x;
                    m_y_next      = cut_y;
                    m_count_next  = total_reg;
                    m_last_next   = is_last_new;
                    widx_next     = widx_reg + IDX_W'(1);
                    prev_next     = rd_data;
                    if (more_segments) begin
                        rd_en      = 1'b1;
                        rd_addr    = {bank_reg, idx_reg + IDX_W'(1)};
                        idx_next   = idx_reg + IDX_W'(1);
                        state_next = ST_CUT_A;
                    end else begin
                        bank_next  = !bank_reg;
                        count_next = total_reg;
                        wp_next    = total_reg[IDX_W-1:0];
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            bank_reg    <= 1'b0;
            wp_reg      <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            bank_reg    <= bank_next;
            wp_reg      <= wp_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        total_reg    <= total_next;
        idx_reg      <= idx_next;
        widx_reg     <= widx_next;
        prev_reg     <= prev_next;
        m_status_reg <= m_status_next;
        m_x_reg      <= m_x_next;
        m_y_reg      <= m_y_next;
        m_count_reg  <= m_count_next;
        m_last_reg   <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = OUT_DW'({m_count_reg, m_y_reg, m_x_reg});
    assign m_tuser  = m_status_reg;
    assign m_tlast  = m_last_reg;

endmodule
